// ===== rtl/core/sle_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sle_pkg
// shared types, character codes and command/status bundles of the line editor
// ---------------------------------------------------------------------------
package sle_pkg;

    localparam int MAX_CHARS = 16;
    localparam int CNT_W     = $clog2(MAX_CHARS);

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_GT    = 8'd62;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_DONE = 1'b1;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    // new line followed by the prompt
    localparam logic [7:0] CRLF_PROMPT_SEQ [5] = '{CH_LF, CH_CR, CH_GT, CH_GT, CH_SPACE};
    localparam logic [7:0] ERASE_SEQ [3]       = '{CH_BS, CH_SPACE, CH_BS};

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        SRC_CONST,
        SRC_RX,
        SRC_LINE
    } emit_src_t;

    typedef struct packed {
        logic       rx_load;
        logic       store_wr;
        logic       count_dec;
        logic       count_clr;
        logic       ptr_clr;
        logic       ptr_inc;
        logic       emit;
        emit_src_t  emit_src;
        logic       emit_kind;
        logic [7:0] emit_byte;
        logic       emit_last;
    } sle_cmd_t;

    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic count_full;
        logic line_last;
    } sle_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/serial_line_editor_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// serial_line_editor_unit
// terminal line editor: echo, backspace, prompt and line submission
// ---------------------------------------------------------------------------
// in_item carries either a received byte (func 0) or a command-done event
// (func 1); out_item carries echo bytes (out_kind 0) and bytes of a
// submitted line (out_kind 1), with last set on the final result of an item.
// Both channels use valid/ready. Items are handled one at a time: in_ready
// is high only while the controller sits idle, and items that cause no
// result leave it idle. Results leave one per cycle, while the output is
// free, through a single output register. An item occupies the block until
// the result sequencer has issued all its results: the echoed byte, the
// erase sequence, line feed, carriage return and prompt, or line feed,
// carriage return and the line bytes of a submit. A stalled out_ready holds
// the output register and pauses the sequencer; no result is lost. Reset
// clears the character count and the waiting flag, and the block starts in
// idle with no result pending; the line store needs no clearing.
// ---------------------------------------------------------------------------
module serial_line_editor_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sle_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sle_pkg::out_item_t      out_item
);

    sle_pkg::sle_cmd_t  cmd;
    sle_pkg::sle_stat_t stat;

    sle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .stat     (stat),
        .cmd      (cmd)
    );

    sle_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

// ===== rtl/core/sle_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sle_datapath
// line store, character count, read pointer and output register
// ---------------------------------------------------------------------------
module sle_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sle_pkg::in_item_t  in_item,
    input  wire sle_pkg::sle_cmd_t  cmd,
    output sle_pkg::sle_stat_t      stat,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sle_pkg::out_item_t      out_item
);

    logic [7:0]              store [sle_pkg::MAX_CHARS];
    logic [sle_pkg::CNT_W-1:0] count_reg, count_next;
    logic [sle_pkg::CNT_W-1:0] ptr_reg, ptr_next;
    logic [7:0]              rd_data_reg;
    logic [7:0]              rx_reg;
    logic                    out_valid_reg, out_valid_next;
    sle_pkg::out_item_t      out_item_reg, out_item_next;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_clr)
        begin
            count_next = '0;
        end
        else if (cmd.store_wr)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - 1'b1;
        end

        ptr_next = ptr_reg;
        if (cmd.ptr_clr)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_item_next = out_item_reg;
        if (cmd.emit)
        begin
            out_item_next.out_kind = cmd.emit_kind;
            out_item_next.last     = cmd.emit_last;
            case (cmd.emit_src)
                sle_pkg::SRC_RX:   out_item_next.out_byte = rx_reg;
                sle_pkg::SRC_LINE: out_item_next.out_byte = rd_data_reg;
                default:           out_item_next.out_byte = cmd.emit_byte;
            endcase
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // store and read port; read data follows the pointer with no lag
    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
        begin
            store[count_reg] <= in_item.rx_byte;
        end
        rd_data_reg <= store[ptr_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rx_load)
        begin
            rx_reg <= in_item.rx_byte;
        end
        out_item_reg <= out_item_next;
    end

    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.count_zero = (count_reg == '0);
    assign stat.count_full = (count_reg == sle_pkg::CNT_W'(sle_pkg::MAX_CHARS - 1));
    assign stat.line_last  = (({1'b0, ptr_reg} + 1'b1) == {1'b0, count_reg});

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_emit_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result written over an item not yet taken");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sle_pkg::CNT_W'(sle_pkg::MAX_CHARS - 1))
        else $error("character count beyond line size");

    a_line_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.emit_src == sle_pkg::SRC_LINE) |-> (ptr_reg < count_reg))
        else $error("line byte read beyond written entries");

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_dec |-> (count_reg != '0))
        else $error("erase on empty line");

endmodule
`default_nettype wire

// ===== rtl/core/sle_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sle_ctrl
// decodes each input item and sequences its results one per cycle while the output is free
// ---------------------------------------------------------------------------
module sle_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sle_pkg::in_item_t  in_item,
    input  wire sle_pkg::sle_stat_t stat,
    output sle_pkg::sle_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ECHO,
        S_ERASE,
        S_PROMPT,
        S_SUBMIT,
        S_LINE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       waiting_reg, waiting_next;
    logic       printable;

    assign printable = (in_item.rx_byte >= sle_pkg::CH_SPACE)
                    && (in_item.rx_byte <= sle_pkg::CH_TILDE);

    always_comb
    begin
        cmd          = '0;
        cmd.emit_src = sle_pkg::SRC_CONST;
        state_next   = state_reg;
        step_next    = step_reg;
        waiting_next = waiting_reg;
        in_ready     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.rx_load = 1'b1;
                    step_next   = '0;
                    if (waiting_reg)
                    begin
                        // bytes are dropped until the command is done
                        if (in_item.func == sle_pkg::FUNC_DONE)
                        begin
                            state_next   = S_PROMPT;
                            waiting_next = 1'b0;
                        end
                    end
                    else if (in_item.func == sle_pkg::FUNC_BYTE)
                    begin
                        unique case (in_item.rx_byte) inside
                            sle_pkg::CH_CR, sle_pkg::CH_LF:
                            begin
                                cmd.ptr_clr = 1'b1;
                                state_next  = stat.count_zero ? S_PROMPT : S_SUBMIT;
                            end
                            sle_pkg::CH_BS, sle_pkg::CH_DEL:
                            begin
                                if (!stat.count_zero)
                                begin
                                    cmd.count_dec = 1'b1;
                                    state_next    = S_ERASE;
                                end
                            end
                            default:
                            begin
                                if (printable)
                                begin
                                    // a full line still echoes but keeps its bytes
                                    cmd.store_wr = !stat.count_full;
                                    state_next   = S_ECHO;
                                end
                            end
                        endcase
                    end
                end
            end
            S_ECHO:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = sle_pkg::SRC_RX;
                    cmd.emit_kind = sle_pkg::KIND_ECHO;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ERASE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = sle_pkg::KIND_ECHO;
                    cmd.emit_byte = sle_pkg::ERASE_SEQ[step_reg[1:0]];
                    cmd.emit_last = (step_reg == 3'd2);
                    step_next     = step_reg + 1'b1;
                    if (step_reg == 3'd2)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_PROMPT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = sle_pkg::KIND_ECHO;
                    cmd.emit_byte = sle_pkg::CRLF_PROMPT_SEQ[step_reg];
                    cmd.emit_last = (step_reg == 3'd4);
                    step_next     = step_reg + 1'b1;
                    if (step_reg == 3'd4)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SUBMIT:
            begin
                // line feed and carriage return ahead of the line bytes
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = sle_pkg::KIND_ECHO;
                    cmd.emit_byte = sle_pkg::CRLF_PROMPT_SEQ[step_reg];
                    step_next     = step_reg + 1'b1;
                    if (step_reg == 3'd1)
                    begin
                        state_next = S_LINE;
                    end
                end
            end
            S_LINE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = sle_pkg::SRC_LINE;
                    cmd.emit_kind = sle_pkg::KIND_LINE;
                    cmd.emit_last = stat.line_last;
                    cmd.ptr_inc   = 1'b1;
                    if (stat.line_last)
                    begin
                        cmd.count_clr = 1'b1;
                        waiting_next  = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            waiting_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            waiting_reg <= waiting_next;
        end
    end

    a_line_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINE) |-> !stat.count_zero)
        else $error("line emission with empty line");

    a_wait_after_submit : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.emit_src == sle_pkg::SRC_LINE && cmd.emit_last) |=> waiting_reg)
        else $error("submit did not enter waiting");

endmodule
`default_nettype wire

// ===== tb/sv/tb_serial_line_editor_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tb_serial_line_editor_unit
// self-checking bench for the terminal line editor
// ---------------------------------------------------------------------------
// A short directed table covers the edge cases: control bytes on an empty
// line, non-printable bytes at both ends of the byte range, erase, submit,
// bytes dropped while waiting, and done events in both states. Random edit
// sessions follow, with typing, erasing, overfilled lines, noise and done
// events. A behavioral line-editor model predicts every FORM_PREDICT result,
// and each output item is checked field by field. The sender runs in bursts
// and the receiver stalls on its own pattern, including one long hold-off.
// ---------------------------------------------------------------------------
module tb_serial_line_editor_unit;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 245;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    // how the expected results of a directed row are obtained
    typedef enum logic [2:0] {
        FORM_PREDICT,
        FORM_NONE,
        FORM_PROMPT,
        FORM_ECHO,
        FORM_ERASE
    } exp_form_t;

    typedef struct packed {
        sle_pkg::in_item_t item;
        exp_form_t         form;
    } dir_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    sle_pkg::in_item_t   in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    sle_pkg::out_item_t  out_item;

    // line editor model state
    logic                          awaiting_done = 1'b0;
    logic [sle_pkg::CNT_W-1:0]     line_len      = '0;
    logic [7:0]                    line_buf [sle_pkg::MAX_CHARS];

    sle_pkg::out_item_t  edit_out [$];
    sle_pkg::out_item_t  pending_out [$];
    int         results_seen = 0;
    int         bad_results  = 0;
    int         items_sent   = 0;
    int         burst_left   = 0;

    serial_line_editor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic sle_pkg::in_item_t make_in(logic f, logic [7:0] b);
        sle_pkg::in_item_t it;
        it.func    = f;
        it.rx_byte = b;
        return it;
    endfunction

    function automatic dir_row_t row(logic f, logic [7:0] b, exp_form_t form);
        dir_row_t r;
        r.item = make_in(f, b);
        r.form = form;
        return r;
    endfunction

    function automatic sle_pkg::out_item_t make_out(logic kind, logic [7:0] b, logic fin);
        sle_pkg::out_item_t o;
        o.out_kind = kind;
        o.out_byte = b;
        o.last     = fin;
        return o;
    endfunction

    function automatic void emit_edit(logic kind, logic [7:0] b);
        edit_out.push_back(make_out(kind, b, 1'b0));
    endfunction

    function automatic void emit_prompt();
        emit_edit(sle_pkg::KIND_ECHO, sle_pkg::CH_LF);
        emit_edit(sle_pkg::KIND_ECHO, sle_pkg::CH_CR);
        emit_edit(sle_pkg::KIND_ECHO, sle_pkg::CH_GT);
        emit_edit(sle_pkg::KIND_ECHO, sle_pkg::CH_GT);
        emit_edit(sle_pkg::KIND_ECHO, sle_pkg::CH_SPACE);
    endfunction

    function automatic logic is_printable(logic [7:0] b);
        return (b >= sle_pkg::CH_SPACE) && (b <= sle_pkg::CH_TILDE);
    endfunction

    // computes the results of one item and advances the editor state
    function automatic void predict_edit(sle_pkg::in_item_t it);
        sle_pkg::out_item_t t;
        logic [7:0] ch;
        ch = it.rx_byte;
        edit_out.delete();
        if (awaiting_done)
        begin
            if (it.func == sle_pkg::FUNC_DONE)
            begin
                emit_prompt();
                awaiting_done = 1'b0;
            end
        end
        else if (it.func == sle_pkg::FUNC_BYTE)
        begin
            if (ch == sle_pkg::CH_CR || ch == sle_pkg::CH_LF)
            begin
                emit_edit(sle_pkg::KIND_ECHO, sle_pkg::CH_LF);
                emit_edit(sle_pkg::KIND_ECHO, sle_pkg::CH_CR);
                if (line_len != 0)
                begin
                    for (int i = 0; i < int'(line_len); i++)
                        emit_edit(sle_pkg::KIND_LINE, line_buf[i]);
                    line_len      = '0;
                    awaiting_done = 1'b1;
                end
                else
                begin
                    emit_edit(sle_pkg::KIND_ECHO, sle_pkg::CH_GT);
                    emit_edit(sle_pkg::KIND_ECHO, sle_pkg::CH_GT);
                    emit_edit(sle_pkg::KIND_ECHO, sle_pkg::CH_SPACE);
                end
            end
            else if (ch == sle_pkg::CH_BS || ch == sle_pkg::CH_DEL)
            begin
                if (line_len != 0)
                begin
                    emit_edit(sle_pkg::KIND_ECHO, sle_pkg::CH_BS);
                    emit_edit(sle_pkg::KIND_ECHO, sle_pkg::CH_SPACE);
                    emit_edit(sle_pkg::KIND_ECHO, sle_pkg::CH_BS);
                    line_len = line_len - 1'b1;
                end
            end
            else if (is_printable(ch))
            begin
                emit_edit(sle_pkg::KIND_ECHO, ch);
                // line full: still echoed, not stored
                if (int'(line_len) < sle_pkg::MAX_CHARS - 1)
                begin
                    line_buf[line_len] = ch;
                    line_len = line_len + 1'b1;
                end
            end
        end
        if (edit_out.size() > 0)
        begin
            t = edit_out[edit_out.size() - 1];
            t.last = 1'b1;
            edit_out[edit_out.size() - 1] = t;
        end
    endfunction

    task automatic offer(sle_pkg::in_item_t it, exp_form_t form);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        predict_edit(it);
        case (form)
            FORM_PREDICT:
                foreach (edit_out[i]) pending_out.push_back(edit_out[i]);
            FORM_PROMPT:
            begin
                pending_out.push_back(make_out(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 1'b0));
                pending_out.push_back(make_out(sle_pkg::KIND_ECHO, sle_pkg::CH_CR, 1'b0));
                pending_out.push_back(make_out(sle_pkg::KIND_ECHO, sle_pkg::CH_GT, 1'b0));
                pending_out.push_back(make_out(sle_pkg::KIND_ECHO, sle_pkg::CH_GT, 1'b0));
                pending_out.push_back(make_out(sle_pkg::KIND_ECHO, sle_pkg::CH_SPACE, 1'b1));
            end
            FORM_ECHO:
                pending_out.push_back(make_out(sle_pkg::KIND_ECHO, it.rx_byte, 1'b1));
            FORM_ERASE:
            begin
                pending_out.push_back(make_out(sle_pkg::KIND_ECHO, sle_pkg::CH_BS, 1'b0));
                pending_out.push_back(make_out(sle_pkg::KIND_ECHO, sle_pkg::CH_SPACE, 1'b0));
                pending_out.push_back(make_out(sle_pkg::KIND_ECHO, sle_pkg::CH_BS, 1'b1));
            end
            default: ;
        endcase
    endtask

    // a byte that is neither printable nor a control code the editor knows
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (is_printable(b) || b == sle_pkg::CH_CR || b == sle_pkg::CH_LF
            || b == sle_pkg::CH_BS || b == sle_pkg::CH_DEL)
            b = b ^ 8'h80;
        return b;
    endfunction

    task automatic release_line();
        if (awaiting_done)
        begin
            repeat ($urandom_range(0, 2))
                offer(make_in(sle_pkg::FUNC_BYTE, 8'($urandom_range(0, 255))), FORM_PREDICT);
            offer(make_in(sle_pkg::FUNC_DONE, 8'($urandom_range(0, 255))), FORM_PREDICT);
        end
    endtask

    // one edit session: type, erase now and then, submit, then release
    task automatic type_line(int len);
        int r;
        logic [7:0] b;
        for (int k = 0; k < len; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                b = r[0] ? sle_pkg::CH_BS : sle_pkg::CH_DEL;
            else if (r < 17)
                b = noise_byte();
            else
                b = 8'($urandom_range(32, 126));
            offer(make_in(sle_pkg::FUNC_BYTE, b), FORM_PREDICT);
        end
        offer(make_in(sle_pkg::FUNC_BYTE,
                      $urandom_range(0, 1) ? sle_pkg::CH_CR : sle_pkg::CH_LF),
              FORM_PREDICT);
        release_line();
    endtask

    task automatic noise_burst();
        logic f;
        repeat ($urandom_range(1, 4))
        begin
            f = ($urandom_range(0, 3) == 0) ? sle_pkg::FUNC_DONE : sle_pkg::FUNC_BYTE;
            offer(make_in(f, 8'($urandom_range(0, 255))), FORM_PREDICT);
        end
        release_line();
    endtask

    initial
    begin : stimulus
        dir_row_t dir_tab [$];
        int r;
        dir_tab = '{
            row(sle_pkg::FUNC_DONE, 8'h00,             FORM_NONE),
            row(sle_pkg::FUNC_BYTE, 8'h00,             FORM_NONE),
            row(sle_pkg::FUNC_BYTE, sle_pkg::CH_BS,    FORM_NONE),
            row(sle_pkg::FUNC_BYTE, sle_pkg::CH_DEL,   FORM_NONE),
            row(sle_pkg::FUNC_BYTE, sle_pkg::CH_CR,    FORM_PROMPT),
            row(sle_pkg::FUNC_BYTE, sle_pkg::CH_LF,    FORM_PROMPT),
            row(sle_pkg::FUNC_BYTE, sle_pkg::CH_SPACE, FORM_ECHO),
            row(sle_pkg::FUNC_BYTE, sle_pkg::CH_TILDE, FORM_ECHO),
            row(sle_pkg::FUNC_BYTE, 8'd31,             FORM_NONE),
            row(sle_pkg::FUNC_BYTE, 8'd128,            FORM_NONE),
            row(sle_pkg::FUNC_BYTE, 8'd255,            FORM_NONE),
            row(sle_pkg::FUNC_DONE, 8'hff,             FORM_NONE),
            row(sle_pkg::FUNC_BYTE, sle_pkg::CH_DEL,   FORM_ERASE),
            row(sle_pkg::FUNC_BYTE, "x",               FORM_PREDICT),
            row(sle_pkg::FUNC_BYTE, "Q",               FORM_PREDICT),
            row(sle_pkg::FUNC_BYTE, sle_pkg::CH_CR,    FORM_PREDICT),
            row(sle_pkg::FUNC_BYTE, "a",               FORM_NONE),
            row(sle_pkg::FUNC_BYTE, sle_pkg::CH_LF,    FORM_NONE),
            row(sle_pkg::FUNC_DONE, 8'h00,             FORM_PROMPT),
            row(sle_pkg::FUNC_BYTE, "z",               FORM_ECHO),
            row(sle_pkg::FUNC_BYTE, sle_pkg::CH_BS,    FORM_ERASE),
            row(sle_pkg::FUNC_BYTE, sle_pkg::CH_BS,    FORM_NONE),
            row(sle_pkg::FUNC_BYTE, "5",               FORM_ECHO),
            row(sle_pkg::FUNC_BYTE, sle_pkg::CH_LF,    FORM_PREDICT),
            row(sle_pkg::FUNC_DONE, 8'h00,             FORM_PROMPT)
        };
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_tab[i])
            offer(dir_tab[i].item, dir_tab[i].form);

        items_sent = 0;
        // start with a line longer than the line size to aim at the full-line case
        type_line(sle_pkg::MAX_CHARS + 2);
        while (items_sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                noise_burst();
            else if (r == 1)
                type_line(0);
            else if (r <= 3)
                type_line($urandom_range(sle_pkg::MAX_CHARS - 2, sle_pkg::MAX_CHARS + 4));
            else
                type_line($urandom_range(1, 10));
        end
        in_valid <= 1'b0;

        while (pending_out.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_results == 0 && pending_out.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // receiver: changing stall patterns plus one long hold-off
    initial
    begin : receiver
        int cyc;
        int mode;
        bit held;
        cyc  = 0;
        mode = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 4) != 0);
                    default: out_ready <= (cyc % 4 != 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        sle_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_out.size() == 0)
            begin
                bad_results++;
                if (bad_results <= MAX_REPORTS)
                    $display("unexpected result: kind=%0d byte=%02h last=%0d",
                             out_item.out_kind, out_item.out_byte, out_item.last);
            end
            else
            begin
                want = pending_out.pop_front();
                if (want.out_kind !== out_item.out_kind ||
                    want.out_byte !== out_item.out_byte ||
                    want.last !== out_item.last)
                begin
                    bad_results++;
                    if (bad_results <= MAX_REPORTS)
                        $display({"result mismatch: exp kind=%0d byte=%02h last=%0d, ",
                                  "got kind=%0d byte=%02h last=%0d"},
                                 want.out_kind, want.out_byte, want.last,
                                 out_item.out_kind, out_item.out_byte, out_item.last);
                end
            end
        end
    end

endmodule
`default_nettype wire
